[hw/rtl/sbdt_pkg.sv]
// ----------------------------------------------------------------------------
// sbdt_pkg: shared definitions for the signed binary to decimal text block
// Character codes, field widths, reset values and the separator decision type.
// ----------------------------------------------------------------------------
package sbdt_pkg;

    localparam int VALUE_WIDTH_DEF = 62;
    localparam int COL_W           = 10;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = COL_W + 1;

    localparam logic [COL_W-1:0]  LINE_WIDTH_RESET = COL_W'(80);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    // Separator decision: whether a byte goes out before the text, and which.
    typedef struct packed {
        logic emit;
        logic newline;
    } t_sep;

endpackage

[hw/rtl/sbdt_in_if.sv]
// ----------------------------------------------------------------------------
// sbdt_in_if: input word channel
// Carries one value to print together with its formatting controls.
// ----------------------------------------------------------------------------
interface sbdt_in_if #(
    parameter int VALUE_WIDTH = sbdt_pkg::VALUE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic                           blank_before;
    logic                           no_break;
    logic [sbdt_pkg::COL_W-1:0]     column;

    modport source (output valid, value, blank_before, no_break, column, input ready);
    modport sink   (input valid, value, blank_before, no_break, column, output ready);
endinterface

[hw/rtl/sbdt_out_if.sv]
// ----------------------------------------------------------------------------
// sbdt_out_if: output word channel
// Carries one ASCII byte of the text and a flag marking the final byte.
// ----------------------------------------------------------------------------
interface sbdt_out_if;
    logic                        valid;
    logic                        ready;
    logic [sbdt_pkg::CHAR_W-1:0] char_out;
    logic                        last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

[hw/rtl/sbdt_cfg_if.sv]
// ----------------------------------------------------------------------------
// sbdt_cfg_if: configuration write channel
// Carries a new line length for the break decisions.
// ----------------------------------------------------------------------------
interface sbdt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sbdt_pkg::COL_W-1:0] line_width;

    modport source (output valid, line_width, input ready);
    modport sink   (input valid, line_width, output ready);
endinterface

[hw/rtl/sbdt_dabble.sv]
// ----------------------------------------------------------------------------
// sbdt_dabble: one shift-add-3 step of the binary to BCD conversion
// Every BCD digit of five or more gets three added, then the BCD and binary
// registers shift left together by one bit.
// ----------------------------------------------------------------------------
module sbdt_dabble #(
    parameter int VALUE_WIDTH = sbdt_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1
) (
    input  logic [NUM_DIGITS*4-1:0] i_bcd,
    input  logic [VALUE_WIDTH-1:0]  i_mag,
    output logic [NUM_DIGITS*4-1:0] o_bcd,
    output logic [VALUE_WIDTH-1:0]  o_mag
);

    logic [NUM_DIGITS*4-1:0] adj;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4];
            end
        end
    end

    assign o_bcd = {adj[NUM_DIGITS*4-2:0], i_mag[VALUE_WIDTH-1]};
    assign o_mag = {i_mag[VALUE_WIDTH-2:0], 1'b0};

endmodule

[hw/rtl/sbdt_sep.sv]
// ----------------------------------------------------------------------------
// sbdt_sep: separator decision
// Decides whether a space or a newline precedes the text from the column,
// the text length and the line length.
// ----------------------------------------------------------------------------
module sbdt_sep (
    input  logic [sbdt_pkg::COL_W-1:0] i_column,
    input  logic [sbdt_pkg::LEN_W-1:0] i_text_len,
    input  logic [sbdt_pkg::COL_W-1:0] i_line_width,
    input  logic                       i_blank_before,
    input  logic                       i_no_break,
    output sbdt_pkg::t_sep             o_sep
);

    logic [sbdt_pkg::LEN_W-1:0] total;
    logic                       reach;
    logic                       over;
    logic                       col_nz;

    assign total  = sbdt_pkg::LEN_W'(i_column) + i_text_len;
    assign reach  = total >= sbdt_pkg::LEN_W'(i_line_width);
    assign over   = total >  sbdt_pkg::LEN_W'(i_line_width);
    assign col_nz = i_column != '0;

    always_comb begin
        if (i_blank_before) begin
            if (!i_no_break && reach) begin
                // A break at column 0 would be an empty line, so nothing goes out.
                o_sep.emit    = col_nz;
                o_sep.newline = 1'b1;
            end else begin
                o_sep.emit    = 1'b1;
                o_sep.newline = 1'b0;
            end
        end else begin
            o_sep.emit    = !i_no_break && col_nz && over;
            o_sep.newline = 1'b1;
        end
    end

endmodule

[hw/rtl/signed_binary_to_decimal_text.sv]
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_text: signed integer to decimal ASCII text
// Converts a two's complement value to its decimal text, most significant
// digit first, with an optional leading space or newline and a minus sign.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                   | Word
//  ---------+-----+-------------------------------------------+-------------------
//  i_in     | in  | value, blank_before, no_break, column     | one value to print
//  o_out    | out | char_out, last                            | one ASCII byte
//  i_cfg    | in  | line_width                                | new line length
//
// One word is accepted, then takes VALUE_WIDTH shift-add-3 steps in the shared
// dabble unit, a scan step per stripped leading zero plus one to stop, the
// separator and sign steps, which also load those bytes, and one step per
// digit. A new value is taken only once the sequencer is back in idle. A
// stalled output holds its byte and the sequencer waits. Reset is synchronous,
// active low; it returns the sequencer to idle, drops the output word and sets
// the line length to 80.
// The configuration channel is always ready and is meant to be written idle.
//
module signed_binary_to_decimal_text #(
    parameter int VALUE_WIDTH = sbdt_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbdt_in_if.sink     i_in,
    sbdt_out_if.source  o_out,
    sbdt_cfg_if.sink    i_cfg
);

    // Enough BCD digits to hold any magnitude of VALUE_WIDTH bits.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int ND_W       = $clog2(NUM_DIGITS + 1);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SEP   = 6'b001000,
        S_SIGN  = 6'b010000,
        S_DIGIT = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [VALUE_WIDTH-1:0]      r_mag, n_mag;
    logic [BCD_W-1:0]            r_bcd, n_bcd;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [ND_W-1:0]             r_nd, n_nd;
    logic                        r_neg, n_neg;
    logic                        r_blank, n_blank;
    logic                        r_nobrk, n_nobrk;
    logic [sbdt_pkg::COL_W-1:0]  r_col, n_col;
    logic [sbdt_pkg::COL_W-1:0]  r_line_len, n_line_len;
    logic                        r_out_valid, n_out_valid;
    logic [sbdt_pkg::CHAR_W-1:0] r_char, n_char;
    logic                        r_last, n_last;

    logic [BCD_W-1:0]            step_bcd;
    logic [VALUE_WIDTH-1:0]      step_mag;
    logic [VALUE_WIDTH-1:0]      in_value;
    logic [3:0]                  top_digit;
    logic [sbdt_pkg::LEN_W-1:0]  text_len;
    sbdt_pkg::t_sep              sep;
    logic                        out_free;

    // The shared conversion unit: one shift-add-3 step per cycle.
    sbdt_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_mag (r_mag),
        .o_bcd (step_bcd),
        .o_mag (step_mag)
    );

    // Text length counts the digits and the minus sign.
    assign text_len = sbdt_pkg::LEN_W'(r_nd) + sbdt_pkg::LEN_W'(r_neg);

    sbdt_sep u_sep (
        .i_column       (r_col),
        .i_text_len     (text_len),
        .i_line_width   (r_line_len),
        .i_blank_before (r_blank),
        .i_no_break     (r_nobrk),
        .o_sep          (sep)
    );

    assign in_value  = VALUE_WIDTH'(i_in.value);
    assign top_digit = r_bcd[BCD_W-1 -: 4];

    // The output register can take a new byte when empty or being drained.
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready     = r_state == S_IDLE;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_nd        = r_nd;
        n_neg       = r_neg;
        n_blank     = r_blank;
        n_nobrk     = r_nobrk;
        n_col       = r_col;
        n_line_len  = r_line_len;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;

        if (i_cfg.valid) begin
            n_line_len = i_cfg.line_width;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // Take the magnitude up front; the most negative value
                    // negates to itself, which is correct read as unsigned.
                    n_neg   = in_value[VALUE_WIDTH-1];
                    n_mag   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    n_nd    = ND_W'(NUM_DIGITS);
                    n_blank = i_in.blank_before;
                    n_nobrk = i_in.no_break;
                    n_col   = i_in.column;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = step_bcd;
                n_mag = step_mag;
                if (r_cnt == '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SCAN: begin
                // Strip leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && r_nd > ND_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_nd  = r_nd - 1'b1;
                end else begin
                    n_state = S_SEP;
                end
            end
            S_SEP: begin
                if (!sep.emit) begin
                    n_state = S_SIGN;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sep.newline ? sbdt_pkg::CHAR_NEWLINE
                                              : sbdt_pkg::CHAR_SPACE;
                    n_last      = 1'b0;
                    n_state     = S_SIGN;
                end
            end
            S_SIGN: begin
                if (!r_neg) begin
                    n_state = S_DIGIT;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sbdt_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sbdt_pkg::CHAR_ZERO + sbdt_pkg::CHAR_W'(top_digit);
                    n_last      = r_nd == ND_W'(1);
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_nd        = r_nd - 1'b1;
                    if (r_nd == ND_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_line_len  <= sbdt_pkg::LINE_WIDTH_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_line_len  <= n_line_len;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_nd    <= n_nd;
        r_neg   <= n_neg;
        r_blank <= n_blank;
        r_nobrk <= n_nobrk;
        r_col   <= n_col;
        r_char  <= n_char;
        r_last  <= n_last;
    end

endmodule
